>>> sv/dgfs_pkg.sv
// Shared constants and types of the direct gravity force sum engine.
`default_nettype none

package dgfs_pkg;

    localparam int MAX_STARS = 1024;
    localparam int DIMS      = 3;
    localparam int AW        = $clog2(MAX_STARS);
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;

    // request kinds carried in the input tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // one stored star, one RAM word
    typedef struct packed {
        logic        active;
        logic [31:0] mass;
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
    } t_star;

    localparam int STAR_W = $bits(t_star);

endpackage

`default_nettype wire

>>> sv/direct_gravity_force_sum_core.sv
// Direct-summation gravity engine: star store, pair sequencer and shared arithmetic units.
`default_nettype none

// Load items (tuser 0) write one star into a 1024-entry RAM.
// Query items (tuser 1) walk stars 0..star_count-1 one pair at a time; each
// pair is read from the RAM, squared through one 32x32 multiplier,
// square-rooted one bit per cycle, multiplied into S*r by shift-add,
// and divided four times by a shared 112-step restoring divider, each
// division with operand setup, term saturation and a saturating add.
// The queried star itself is passed over; a zero-separation pair stops
// after its squares and sets the coincident flag; an inactive or
// out-of-range star answers with the skipped flag and walks no pair. One
// query is in work at a time; its result waits in an output register while
// the next item enters.
// Stars must be loaded before they are summed: the store has no reset.

module direct_gravity_force_sum_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // star_index, pos_x, pos_y, pos_z, star_mass, is_active (lowest first)
    input  wire logic [143:0]                    s_axis_tdata,
    // req_type
    input  wire logic [0:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // acc_x, acc_y, acc_z, potential (lowest first)
    output logic [255:0]                         m_axis_tdata,
    // skipped, overflow, coincident (lowest first)
    output logic [2:0]                           m_axis_tuser,
    input  wire logic                            i_cfg_we,
    input  wire logic [dgfs_pkg::CNT_W-1:0]      i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD_I, S_RD, S_DIFF, S_SQ, S_CHK, S_SQRT, S_DEN,
        S_MUL, S_DSET, S_DIV, S_TERM, S_ADD, S_FIN
    } t_state;

    localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

    t_state                         r_state;
    logic [dgfs_pkg::CNT_W-1:0]     r_cfg_cnt;
    logic [dgfs_pkg::IDX_W-1:0]     r_i;
    logic [dgfs_pkg::CNT_W-1:0]     r_j;
    logic signed [31:0]             r_pi [3];
    logic [31:0]                    r_ad [3];
    logic                           r_ng [3];
    logic [31:0]                    r_mass;
    logic [63:0]                    r_prod;
    logic [65:0]                    r_s;
    logic [67:0]                    r_srad;
    logic [35:0]                    r_srem;
    logic [33:0]                    r_root;
    logic [33:0]                    r_rsh;
    logic [99:0]                    r_den;
    logic [99:0]                    r_dvs;
    logic [99:0]                    r_rem;
    logic [111:0]                   r_num;
    logic signed [63:0]             r_term;
    logic signed [63:0]             r_sum [4];
    logic                           r_ovf;
    logic                           r_coin;
    logic                           r_skip;
    logic [1:0]                     r_op;
    logic [6:0]                     r_cnt;
    logic                           r_ov;
    logic [255:0]                   r_out_data;
    logic [2:0]                     r_out_user;

    // input fields
    logic                           in_req;
    logic [dgfs_pkg::IDX_W-1:0]     in_idx;
    dgfs_pkg::t_star                in_star;
    logic                           in_acc;

    assign in_req         = s_axis_tuser[0];
    assign in_idx         = s_axis_tdata[9:0];
    assign in_star.px     = s_axis_tdata[41:10];
    assign in_star.py     = s_axis_tdata[73:42];
    assign in_star.pz     = s_axis_tdata[105:74];
    assign in_star.mass   = s_axis_tdata[137:106];
    assign in_star.active = s_axis_tdata[138];
    assign s_axis_tready  = (r_state == S_IDLE);
    assign in_acc         = s_axis_tvalid && s_axis_tready;

    // effective star count
    logic [dgfs_pkg::CNT_W-1:0] cnt_eff;
    assign cnt_eff = (r_cfg_cnt > dgfs_pkg::CNT_W'(dgfs_pkg::MAX_STARS))
                   ? dgfs_pkg::CNT_W'(dgfs_pkg::MAX_STARS) : r_cfg_cnt;

    // star store
    logic                           ram_we;
    logic [dgfs_pkg::AW-1:0]        ram_raddr;
    logic [dgfs_pkg::STAR_W-1:0]    ram_rdata;
    dgfs_pkg::t_star                rd;

    assign ram_we = in_acc && (in_req == dgfs_pkg::REQ_LOAD)
                 && (32'(in_idx) < dgfs_pkg::MAX_STARS);
    assign ram_raddr = (r_state == S_IDLE) ? dgfs_pkg::AW'(in_idx)
                                           : r_j[dgfs_pkg::AW-1:0];
    assign rd = dgfs_pkg::t_star'(ram_rdata);

    dgfs_ram #(
        .WIDTH (dgfs_pkg::STAR_W),
        .DEPTH (dgfs_pkg::MAX_STARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (dgfs_pkg::AW'(in_idx)),
        .i_wdata (in_star),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // separation per axis, axes past DIMS read as zero
    logic [31:0] d_abs [3];
    logic        d_neg [3];
    always_comb begin
        logic signed [32:0] d;
        logic signed [31:0] pj;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0:       pj = rd.px;
                1:       pj = rd.py;
                default: pj = rd.pz;
            endcase
            d = {pj[31], pj} - {r_pi[k][31], r_pi[k]};
            if (k >= dgfs_pkg::DIMS) begin
                d = '0;
            end
            d_neg[k] = d[32];
            d_abs[k] = d[32] ? 32'(-d) : d[31:0];
        end
    end

    // shared 32x32 multiplier
    logic [31:0] mul_a, mul_b, ad_sel;
    logic [63:0] mul_p;
    logic [1:0]  ax;
    always_comb begin
        ax = (r_state == S_SQ) ? r_cnt[1:0] : (r_op - 2'd1);
        case (ax)
            2'd0:    ad_sel = r_ad[0];
            2'd1:    ad_sel = r_ad[1];
            2'd2:    ad_sel = r_ad[2];
            default: ad_sel = '0;
        endcase
        mul_a = (r_state == S_SQ) ? ad_sel : r_mass;
        mul_b = ad_sel;
        mul_p = {32'b0, mul_a} * {32'b0, mul_b};
    end

    // one square-root digit per cycle
    logic [37:0] sq_t, sq_trial;
    logic        sq_ge;
    logic [33:0] root_nx;
    assign sq_t     = {r_srem, r_srad[67:66]};
    assign sq_trial = 38'({r_root, 2'b01});
    assign sq_ge    = (sq_t >= sq_trial);
    assign root_nx  = {r_root[32:0], sq_ge};

    // one quotient bit per cycle
    logic [100:0] dv_t, dv_sub;
    logic         dv_ge;
    assign dv_t   = {r_rem, r_num[111]};
    assign dv_sub = dv_t - {1'b0, r_dvs};
    assign dv_ge  = (dv_t >= {1'b0, r_dvs});

    // quotient to saturated signed term
    logic               t_neg;
    logic signed [63:0] term_v;
    logic               term_ovf;
    always_comb begin
        case (r_op)
            2'd1:    t_neg = r_ng[0];
            2'd2:    t_neg = r_ng[1];
            2'd3:    t_neg = r_ng[2];
            default: t_neg = 1'b0;
        endcase
        term_ovf = 1'b0;
        if (t_neg) begin
            if (r_num[111:64] != '0 || (r_num[63] && r_num[62:0] != '0)) begin
                term_ovf = 1'b1;
                term_v   = SUM_MIN;
            end else begin
                term_v = -$signed(r_num[63:0]);
            end
        end else begin
            if (r_num[111:63] != '0) begin
                term_ovf = 1'b1;
                term_v   = SUM_MAX;
            end else begin
                term_v = $signed(r_num[63:0]);
            end
        end
    end

    // saturating accumulate
    logic signed [63:0] acc_a, acc_v;
    logic [64:0]        acc_w;
    logic               acc_ovf;
    always_comb begin
        acc_a   = r_sum[r_op];
        acc_w   = {acc_a[63], acc_a} + {r_term[63], r_term};
        acc_ovf = (acc_w[64] != acc_w[63]);
        acc_v   = acc_ovf ? (acc_w[64] ? SUM_MIN : SUM_MAX) : $signed(acc_w[63:0]);
    end

    logic [dgfs_pkg::CNT_W-1:0] j_nx;
    assign j_nx = r_j + 1'b1;

    // result moves into the output register
    logic fin_fire;
    assign fin_fire = (r_state == S_FIN) && (!r_ov || m_axis_tready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_cnt <= dgfs_pkg::CNT_W'(1);
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_cnt <= i_cfg_wdata;
            end
            if (fin_fire) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && in_req == dgfs_pkg::REQ_QUERY) begin
                        r_i    <= in_idx;
                        r_j    <= '0;
                        r_ovf  <= 1'b0;
                        r_coin <= 1'b0;
                        r_skip <= 1'b0;
                        for (int k = 0; k < 4; k++) begin
                            r_sum[k] <= '0;
                        end
                        r_state <= S_LOAD_I;
                    end
                end
                S_LOAD_I: begin
                    r_pi[0] <= rd.px;
                    r_pi[1] <= rd.py;
                    r_pi[2] <= rd.pz;
                    if ({1'b0, r_i} >= cnt_eff || !rd.active) begin
                        r_skip  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    if (r_j == {1'b0, r_i}) begin
                        r_j     <= j_nx;
                        r_state <= (j_nx >= cnt_eff) ? S_FIN : S_RD;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            r_ad[k] <= d_abs[k];
                            r_ng[k] <= d_neg[k];
                        end
                        r_mass  <= rd.mass;
                        r_s     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // square one axis, add the previous square
                    r_prod <= mul_p;
                    if (r_cnt != '0) begin
                        r_s <= r_s + 66'(r_prod);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd3) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_s == '0) begin
                        r_coin  <= 1'b1;
                        r_j     <= j_nx;
                        r_state <= (j_nx >= cnt_eff) ? S_FIN : S_RD;
                    end else begin
                        r_srad  <= {2'b00, r_s};
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srad <= {r_srad[65:0], 2'b00};
                    r_srem <= sq_ge ? 36'(sq_t - sq_trial) : 36'(sq_t);
                    r_root <= root_nx;
                    if (r_cnt == 7'd33) begin
                        r_rsh   <= root_nx;
                        r_den   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DEN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DEN: begin
                    // S * r, one root bit per cycle from the top
                    r_den <= {r_den[98:0], 1'b0} + (r_rsh[33] ? 100'(r_s) : 100'd0);
                    r_rsh <= {r_rsh[32:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd33) begin
                        r_op    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    if (r_op == '0) begin
                        r_num <= {48'b0, r_mass, 32'b0};
                        r_dvs <= {66'b0, r_root};
                    end else begin
                        r_num <= {r_prod, 48'b0};
                        r_dvs <= r_den;
                    end
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= dv_ge ? dv_sub[99:0] : dv_t[99:0];
                    r_num <= {r_num[110:0], dv_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd111) begin
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    r_term  <= term_v;
                    r_ovf   <= r_ovf | term_ovf;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum[r_op] <= acc_v;
                    r_ovf       <= r_ovf | acc_ovf;
                    if (r_op == 2'd3) begin
                        r_j     <= j_nx;
                        r_state <= (j_nx >= cnt_eff) ? S_FIN : S_RD;
                    end else begin
                        r_op    <= r_op + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (fin_fire) begin
                        r_out_data <= {r_sum[0], r_sum[3], r_sum[2], r_sum[1]};
                        r_out_user <= {r_coin, r_ovf, r_skip};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // a skipped star reports zero sums
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("skipped item with nonzero sums");

    // a skipped star raises no other flag
    a_skip_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == 2'b00)
        else $error("skipped item with flags set");

    // pair walk stays below the count
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIFF |-> r_j < cnt_eff)
        else $error("pair index past star count");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_dvs)
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

>>> sv/dgfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dgfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
